@@ hdl/rqs_pkg.sv @@
// shared types and constants of the ready queue process scheduler
package rqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int QC_W      = 5;
  localparam int ID_W      = 8;
  localparam int PRIO_W    = 16;
  localparam int TIME_W    = 16;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SJF  = 2'd1,
    MODE_PRIO = 2'd2
  } rqs_mode_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_REJECT   = 3'd1,
    STAT_REQUEUED = 3'd2,
    STAT_FINISHED = 3'd3,
    STAT_IDLE     = 3'd4
  } rqs_status_t;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } rqs_req_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_REQUEUE = 1'b1
  } rqs_state_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [TIME_W-1:0]        need;
    logic [TIME_W-1:0]        elapsed;
  } rqs_entry_t;

  // control broadcast to every cell of the queue
  typedef struct packed {
    logic       ins_en;
    logic       pop_en;
    logic [1:0] mode;
  } rqs_ctl_t;

endpackage

@@ hdl/rqs_if.sv @@
// channel interfaces of the ready queue process scheduler
interface rqs_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  proc_id;
  logic signed [15:0] priority_req;
  logic [15:0] needed_time;

  modport source(output valid, req_type, proc_id, priority_req, needed_time, input ready);
  modport sink(input valid, req_type, proc_id, priority_req, needed_time, output ready);
endinterface

interface rqs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  ran_id;
  logic signed [15:0] ran_priority;
  logic [15:0] ran_time;
  logic [4:0]  queue_count;

  modport source(output valid, status, ran_id, ran_priority, ran_time, queue_count,
                 input ready);
  modport sink(input valid, status, ran_id, ran_priority, ran_time, queue_count,
               output ready);
endinterface

interface rqs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ hdl/rqs_cell.sv @@
// one slot of the shift-cell ready queue
module rqs_cell (
  input  logic               clk,
  input  rqs_pkg::rqs_ctl_t  ctl,
  input  logic               occupied,
  input  logic               found_in,
  input  rqs_pkg::rqs_entry_t left_entry,
  input  rqs_pkg::rqs_entry_t right_entry,
  input  rqs_pkg::rqs_entry_t new_entry,
  output rqs_pkg::rqs_entry_t entry,
  output logic               found_out
);

  rqs_pkg::rqs_entry_t entry_r;
  logic                cond;
  logic                take_new;

  // new item belongs in front of this entry
  always_comb begin
    case (ctl.mode)
      rqs_pkg::MODE_SJF:  cond = occupied && (entry_r.need > new_entry.need);
      rqs_pkg::MODE_PRIO: cond = occupied && (entry_r.prio < new_entry.prio);
      default:            cond = 1'b0;
    endcase
  end

  assign take_new  = !found_in && (cond || !occupied);
  assign found_out = found_in || cond || !occupied;

  // pop shifts toward the head, insert shifts toward the tail
  always_ff @(posedge clk) begin
    if (ctl.pop_en) begin
      entry_r <= right_entry;
    end else if (ctl.ins_en) begin
      if (found_in) begin
        entry_r <= left_entry;
      end else if (take_new) begin
        entry_r <= new_entry;
      end
    end
  end

  assign entry = entry_r;

endmodule

@@ hdl/ready_queue_process_scheduler.sv @@
// top level of the ready queue process scheduler
//
// Bounded ready queue of up to rqs_pkg::MAX_PROCS processes held in a row of
// shift cells. Channels: in_ch carries add and tick requests, out_ch returns
// exactly one result transaction per request, cfg_ch writes the ordering mode
// (first come first served, shortest job first, priority).
// An add is compared against every cell at once; the first cell that the new
// process must precede, or else the first empty cell, takes it and all later cells shift one place back.
// A tick pops the head (all cells shift forward) and reports the result in
// the same cycle; a process that still needs time is reinserted in the
// following cycle, with in_ch.ready low for that one cycle.
// The result is registered and valid in the cycle after acceptance.
// Throughput: one add per cycle, one tick per cycle when the head finishes,
// while results are taken; a tick that requeues holds in_ch for the single reinsert pass.
// Stall: one output register; a request is taken only when that register is
// empty or being drained, so a stalled receiver holds back in_ch.ready.
// Reset (rst_n low, synchronous) empties the queue and sets the mode to first
// come first served; no clearing pass is needed.
module ready_queue_process_scheduler (
  input  logic             clk,
  input  logic             rst_n,
  rqs_in_if.sink           in_ch,
  rqs_out_if.source        out_ch,
  rqs_cfg_if.sink          cfg_ch
);

  localparam int N = rqs_pkg::MAX_PROCS;

  rqs_pkg::rqs_state_t state_r, state_nxt;
  logic [rqs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [1:0]          mode_r;
  rqs_pkg::rqs_entry_t pend_r;

  logic                        out_valid_r;
  rqs_pkg::rqs_status_t        out_status_r;
  logic [rqs_pkg::ID_W-1:0]    out_id_r;
  logic signed [rqs_pkg::PRIO_W-1:0] out_prio_r;
  logic [rqs_pkg::TIME_W-1:0]  out_time_r;
  logic [rqs_pkg::QC_W-1:0]    out_qc_r;

  rqs_pkg::rqs_entry_t cell_q [N];
  logic [N:0]          found;
  rqs_pkg::rqs_ctl_t   ctl;
  rqs_pkg::rqs_entry_t add_entry;
  rqs_pkg::rqs_entry_t ins_entry;

  logic in_fire;
  logic is_tick;
  logic full;
  logic empty;
  logic finished;
  logic [rqs_pkg::TIME_W-1:0]  rtime_inc;
  logic signed [rqs_pkg::PRIO_W-1:0] prio_dec;
  logic [rqs_pkg::QC_W-1:0]    qc_val;
  rqs_pkg::rqs_status_t        status_val;

  assign in_ch.ready  = (state_r == rqs_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_tick      = (in_ch.req_type == rqs_pkg::REQ_TICK);
  assign full         = (count_r == rqs_pkg::CNT_W'(N));
  assign empty        = (count_r == '0);

  // head process after this tick
  assign rtime_inc = (cell_q[0].elapsed != '1) ? cell_q[0].elapsed + 1'b1
                                               : cell_q[0].elapsed;
  assign finished  = (rtime_inc >= cell_q[0].need);
  assign prio_dec  = (cell_q[0].prio != {1'b1, {(rqs_pkg::PRIO_W-1){1'b0}}})
                     ? cell_q[0].prio - 1'b1 : cell_q[0].prio;

  // new process from the request, zero needed time counts as one
  always_comb begin
    add_entry.id      = in_ch.proc_id;
    add_entry.prio    = in_ch.priority_req;
    add_entry.need    = (in_ch.needed_time == '0) ? rqs_pkg::TIME_W'(1) : in_ch.needed_time;
    add_entry.elapsed = '0;
  end

  // queue control
  always_comb begin
    ctl.mode   = mode_r;
    ctl.pop_en = in_fire && is_tick && !empty;
    ctl.ins_en = (in_fire && !is_tick && !full) || (state_r == rqs_pkg::ST_REQUEUE);
    ins_entry  = (state_r == rqs_pkg::ST_REQUEUE) ? pend_r : add_entry;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rqs_pkg::ST_IDLE: begin
        if (ctl.pop_en && !finished) begin
          state_nxt = rqs_pkg::ST_REQUEUE;
        end
      end
      rqs_pkg::ST_REQUEUE: state_nxt = rqs_pkg::ST_IDLE;
      default:             state_nxt = rqs_pkg::ST_IDLE;
    endcase
  end

  // waiting count
  always_comb begin
    count_nxt = count_r;
    if (state_r == rqs_pkg::ST_REQUEUE) begin
      count_nxt = rqs_pkg::CNT_W'(count_r + 1'b1);
    end else if (ctl.pop_en) begin
      count_nxt = rqs_pkg::CNT_W'(count_r - 1'b1);
    end else if (ctl.ins_en) begin
      count_nxt = rqs_pkg::CNT_W'(count_r + 1'b1);
    end
  end

  // result of the accepted transaction
  always_comb begin
    if (!is_tick) begin
      status_val = full ? rqs_pkg::STAT_REJECT : rqs_pkg::STAT_ADDED;
      qc_val     = full ? rqs_pkg::QC_W'(count_r) : rqs_pkg::QC_W'(count_r + 1'b1);
    end else if (empty) begin
      status_val = rqs_pkg::STAT_IDLE;
      qc_val     = '0;
    end else if (finished) begin
      status_val = rqs_pkg::STAT_FINISHED;
      qc_val     = rqs_pkg::QC_W'(count_r - 1'b1);
    end else begin
      status_val = rqs_pkg::STAT_REQUEUED;
      qc_val     = rqs_pkg::QC_W'(count_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rqs_pkg::ST_IDLE;
      count_r     <= '0;
      mode_r      <= rqs_pkg::MODE_FCFS;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        mode_r <= cfg_ch.data;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload and pending reinsert, a finishing process keeps its priority
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status_val;
      out_qc_r     <= qc_val;
      if (ctl.pop_en) begin
        out_id_r   <= cell_q[0].id;
        out_prio_r <= finished ? cell_q[0].prio : prio_dec;
        out_time_r <= rtime_inc;
      end else begin
        out_id_r   <= '0;
        out_prio_r <= '0;
        out_time_r <= '0;
      end
    end
    if (ctl.pop_en) begin
      pend_r.id      <= cell_q[0].id;
      pend_r.prio    <= prio_dec;
      pend_r.need    <= cell_q[0].need;
      pend_r.elapsed <= rtime_inc;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.ran_id       = out_id_r;
  assign out_ch.ran_priority = out_prio_r;
  assign out_ch.ran_time     = out_time_r;
  assign out_ch.queue_count  = out_qc_r;

  // row of queue cells, insert position found by a chain along the row
  assign found[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count_r > rqs_pkg::CNT_W'(i)),
      .found_in   (found[i]),
      .left_entry ((i == 0) ? ins_entry : cell_q[(i == 0) ? 0 : i - 1]),
      .right_entry(cell_q[(i == N - 1) ? i : i + 1]),
      .new_entry  (ins_entry),
      .entry      (cell_q[i]),
      .found_out  (found[i + 1])
    );
  end

endmodule

@@ hdl/rqs_checker.sv @@
// port-level checks of the ready queue process scheduler, bound to the top level
module rqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_ran_id,
  input logic [4:0]  out_queue_count
);

  // queue never reports more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queue_count <= 5'(rqs_pkg::MAX_PROCS)))
    else $error("queue count above capacity");

  // a reject only happens on a full queue
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rqs_pkg::STAT_REJECT)
      |-> (out_queue_count == 5'(rqs_pkg::MAX_PROCS)))
    else $error("reject with room in queue");

  // an idle tick leaves the queue empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rqs_pkg::STAT_IDLE) |-> (out_queue_count == '0))
    else $error("idle tick with waiting processes");

  // a requeued or added process is waiting afterwards
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == rqs_pkg::STAT_ADDED) ||
                  (out_status == rqs_pkg::STAT_REQUEUED))
      |-> (out_queue_count != '0))
    else $error("queue empty after add or requeue");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
      |=> out_valid && $stable(out_status) && $stable(out_ran_id))
    else $error("result changed while stalled");

endmodule

bind ready_queue_process_scheduler rqs_checker u_rqs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_ran_id     (out_ch.ran_id),
  .out_queue_count(out_ch.queue_count)
);
